@@ hdl/okin_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package okin_pkg;

  localparam int WHEELS = 4;
  localparam int DIV_DW = 26;
  localparam int DIV_QW = 33;
  localparam int NUM_W  = DIV_DW + DIV_QW;

  localparam logic [1:0] CFG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] CFG_HALF_LENGTH  = 2'd1;
  localparam logic [1:0] CFG_GEAR_RATIO   = 2'd2;

  localparam logic OP_FORWARD = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  localparam logic [23:0] RADIUS_RESET = 24'd6554;
  localparam logic [23:0] HALF_LENGTH_RESET = 24'd19661;
  localparam logic [23:0] GEAR_RESET = 24'd65536;

  localparam logic [12:0] RPM2RAD = 13'd6862;
  localparam logic [19:0] RAD2RPM = 20'd625823;

  localparam logic [31:0] INT32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] INT32_MIN = 32'h8000_0000;

  typedef struct packed {
    logic               sat;
    logic signed [31:0] val;
  } res_t;

  typedef struct packed {
    logic [DIV_QW-1:0] lo;
    logic [DIV_DW-1:0] rem;
    logic              neg;
    logic              zero;
    logic              ovf;
  } prep_t;

  typedef struct packed {
    logic              op;
    logic [WHEELS-1:0] neg;
    logic [WHEELS-1:0] zero;
    logic [WHEELS-1:0] ovf;
  } diva_tag_t;

  typedef struct packed {
    logic                          op;
    logic                          sat;
    logic                          neg;
    logic                          zero;
    logic                          ovf;
    logic [31:0]                   vx;
    logic [31:0]                   vy;
    logic [WHEELS-1:0][31:0]       motor;
  } divb_tag_t;

  function automatic res_t sat32(input logic signed [63:0] x);
    logic [32:0] hi;
    res_t        r;
    hi = x[63:31];
    if (hi == '0 || hi == '1) begin
      r.sat = 1'b0;
      r.val = x[31:0];
    end else begin
      r.sat = 1'b1;
      r.val = x[63] ? INT32_MIN : INT32_MAX;
    end
    return r;
  endfunction

  // The dividend is turned into magnitude plus half the divisor in one add.
  function automatic prep_t div_prep(input logic signed [NUM_W-1:0] num,
                                     input logic [DIV_DW-1:0] d);
    logic [NUM_W-1:0]  base;
    logic [NUM_W-1:0]  addend;
    logic [NUM_W-1:0]  dd;
    logic [DIV_DW-1:0] h;
    prep_t             p;
    p.neg  = num[NUM_W-1];
    h      = d >> 1;
    base   = p.neg ? ~num : num;
    addend = p.neg ? NUM_W'(h) + NUM_W'(1) : NUM_W'(h);
    dd     = base + addend;
    p.zero = (num == '0);
    p.ovf  = (dd[NUM_W-1:DIV_QW] >= d);
    p.rem  = p.ovf ? '0 : dd[NUM_W-1:DIV_QW];
    p.lo   = dd[DIV_QW-1:0];
    return p;
  endfunction

  function automatic res_t div_result(input logic [DIV_QW-1:0] q, input logic neg,
                                      input logic zero, input logic ovf);
    res_t r;
    r.sat = 1'b0;
    r.val = '0;
    if (zero) begin
      r.val = '0;
    end else if (ovf) begin
      r.sat = 1'b1;
      r.val = neg ? INT32_MIN : INT32_MAX;
    end else if (neg) begin
      if (q > {1'b0, INT32_MIN}) begin
        r.sat = 1'b1;
        r.val = INT32_MIN;
      end else begin
        r.val = -q[31:0];
      end
    end else begin
      if (q > {1'b0, INT32_MAX}) begin
        r.sat = 1'b1;
        r.val = INT32_MAX;
      end else begin
        r.val = q[31:0];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/okin_div.sv @@
`timescale 1ns / 1ps
`default_nettype none

module okin_div
  import okin_pkg::*;
#(
  parameter int LANES = 4,
  parameter int TW    = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [DIV_DW-1:0]                in_div,
  input  wire logic [LANES-1:0][DIV_DW-1:0]     in_rem,
  input  wire logic [LANES-1:0][DIV_QW-1:0]     in_lo,
  input  wire logic [TW-1:0]                    in_tag,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [LANES-1:0][DIV_QW-1:0]          out_q,
  output logic [TW-1:0]                         out_tag
);

  logic [DIV_QW-1:0]                v_r;
  logic [DIV_QW:0]                  en;
  logic [LANES-1:0][DIV_DW-1:0]     rem_r   [DIV_QW];
  logic [LANES-1:0][DIV_DW-1:0]     rem_nxt [DIV_QW];
  logic [LANES-1:0][DIV_QW-1:0]     lo_r    [DIV_QW];
  logic [LANES-1:0][DIV_QW-1:0]     lo_nxt  [DIV_QW];
  logic [LANES-1:0][DIV_QW-1:0]     q_r     [DIV_QW];
  logic [LANES-1:0][DIV_QW-1:0]     q_nxt   [DIV_QW];
  logic [DIV_DW-1:0]                d_r     [DIV_QW];
  logic [TW-1:0]                    tag_r   [DIV_QW];

  always_comb begin
    en[DIV_QW] = out_ready;
    for (int s = DIV_QW - 1; s >= 0; s--) begin
      en[s] = !v_r[s] || en[s+1];
    end
  end

  always_comb begin
    logic [DIV_DW-1:0] src_rem;
    logic [DIV_QW-1:0] src_lo;
    logic [DIV_QW-1:0] src_q;
    logic [DIV_DW-1:0] src_d;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    for (int s = 0; s < DIV_QW; s++) begin
      for (int l = 0; l < LANES; l++) begin
        if (s == 0) begin
          src_rem = in_rem[l];
          src_lo  = in_lo[l];
          src_q   = '0;
          src_d   = in_div;
        end else begin
          src_rem = rem_r[s-1][l];
          src_lo  = lo_r[s-1][l];
          src_q   = q_r[s-1][l];
          src_d   = d_r[s-1];
        end
        trial = {src_rem, src_lo[DIV_QW-1]};
        diff  = trial - {1'b0, src_d};
        if (!diff[DIV_DW]) begin
          rem_nxt[s][l] = diff[DIV_DW-1:0];
          q_nxt[s][l]   = {src_q[DIV_QW-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = trial[DIV_DW-1:0];
          q_nxt[s][l]   = {src_q[DIV_QW-2:0], 1'b0};
        end
        lo_nxt[s][l] = {src_lo[DIV_QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int s = 0; s < DIV_QW; s++) begin
        if (en[s]) begin
          v_r[s] <= (s == 0) ? in_valid : v_r[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_QW; s++) begin
      if (en[s]) begin
        rem_r[s] <= rem_nxt[s];
        lo_r[s]  <= lo_nxt[s];
        q_r[s]   <= q_nxt[s];
        d_r[s]   <= (s == 0) ? in_div : d_r[s-1];
        tag_r[s] <= (s == 0) ? in_tag : tag_r[s-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[DIV_QW-1];
  assign out_q     = q_r[DIV_QW-1];
  assign out_tag   = tag_r[DIV_QW-1];

  a_take_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("accepted transfer did not enter the first divider stage");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && d_r[0] != '0 |-> rem_r[0][0] < d_r[0])
    else $error("partial remainder not below divisor");

  a_fill_rate: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(v_r) <= $countones($past(v_r)) + 1)
    else $error("divider occupancy grew by more than one transfer");

endmodule

`default_nettype wire

@@ hdl/omni4_wheel_kinematics.sv @@
// Four-wheel omni drive kinematics, signed Q16.16 fixed point.
// Configuration: write cfg_wdata into register cfg_index (0 wheel radius,
// 1 half length, 2 gear ratio) while cfg_we is high. Write only while idle.
// Input channel: in_valid/in_ready with in_op selecting forward (motor rpm
// to body velocity) or inverse (body velocity to motor rpm).
// Output channel: out_valid/out_ready carrying the seven results and the
// saturated flag. The results of the unused direction are zero.
// An input transfer passes through three input stages, a 33-stage divider
// for the per-wheel division, five stages for sums and multiplies, a second
// 33-stage divider for the yaw rate, and the output register to out_valid.
// One transfer per cycle is accepted while the receiver takes results.
// Each stage holds its own valid bit; a stalled receiver stops only the
// stages that are full, so empty stages keep filling and nothing is lost.
// Reset is synchronous, clears all valid bits and loads the register
// defaults; the block is ready in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module omni4_wheel_kinematics
  import okin_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [23:0]        cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic signed [31:0] in_wheel_lf,
  input  wire logic signed [31:0] in_wheel_lb,
  input  wire logic signed [31:0] in_wheel_rb,
  input  wire logic signed [31:0] in_wheel_rf,
  input  wire logic signed [31:0] in_cmd_vx,
  input  wire logic signed [31:0] in_cmd_vy,
  input  wire logic signed [31:0] in_cmd_wz,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_body_vx,
  output logic signed [31:0]      out_body_vy,
  output logic signed [31:0]      out_body_wz,
  output logic signed [31:0]      out_motor_lf,
  output logic signed [31:0]      out_motor_lb,
  output logic signed [31:0]      out_motor_rb,
  output logic signed [31:0]      out_motor_rf,
  output logic                    out_saturated
);

  logic [23:0] wheel_radius_r;
  logic [23:0] half_length_r;
  logic [23:0] gear_ratio_r;

  logic v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6, en7, en8, en9;
  logic diva_in_ready, diva_out_valid, divb_in_ready, divb_out_valid;

  logic signed [31:0] wheel_in [WHEELS];

  logic               s1_op_r;
  logic signed [45:0] s1_pf_r  [WHEELS];
  logic signed [45:0] s1_pf_nxt [WHEELS];
  logic signed [56:0] s1_a_r;
  logic signed [56:0] s1_a_nxt;
  logic signed [32:0] s1_dif_r, s1_sum_r;

  logic                   s2_op_r;
  logic signed [NUM_W-1:0] s2_num_r   [WHEELS];
  logic signed [NUM_W-1:0] s2_num_nxt [WHEELS];

  logic [WHEELS-1:0][DIV_DW-1:0] s3_rem_r, s3_rem_nxt;
  logic [WHEELS-1:0][DIV_QW-1:0] s3_lo_r, s3_lo_nxt;
  logic [DIV_DW-1:0]             s3_d_r, s3_d_nxt;
  diva_tag_t                     s3_tag_r, s3_tag_nxt;

  logic [WHEELS-1:0][DIV_QW-1:0] qa;
  diva_tag_t                     qa_tag;

  logic               s4_op_r, s4_sat_r, s4_sat_nxt;
  logic signed [31:0] s4_r_r   [WHEELS];
  logic signed [31:0] s4_r_nxt [WHEELS];

  logic               s5_op_r, s5_sat_r;
  logic signed [33:0] s5_sum_r  [3];
  logic signed [33:0] s5_sum_nxt [3];
  logic signed [56:0] s5_wg_r   [WHEELS];
  logic signed [56:0] s5_wg_nxt [WHEELS];

  logic               s6_op_r, s6_sat_r;
  logic signed [58:0] s6_pr_r   [3];
  logic signed [58:0] s6_pr_nxt [3];
  logic signed [40:0] s6_t_r    [WHEELS];
  logic signed [40:0] s6_t_nxt  [WHEELS];

  logic               s7_op_r, s7_sat_r, s7_sat_nxt;
  logic signed [31:0] s7_vx_r, s7_vy_r, s7_vx_nxt, s7_vy_nxt;
  logic signed [58:0] s7_wnum_r;
  logic signed [61:0] s7_m_r   [WHEELS];
  logic signed [61:0] s7_m_nxt [WHEELS];

  logic [0:0][DIV_DW-1:0] s8_rem_r, s8_rem_nxt;
  logic [0:0][DIV_QW-1:0] s8_lo_r, s8_lo_nxt;
  divb_tag_t              s8_tag_r, s8_tag_nxt;

  logic [0:0][DIV_QW-1:0] qb;
  divb_tag_t              qb_tag;

  logic signed [31:0] out_body_vx_r, out_body_vy_r, out_body_wz_r;
  logic signed [31:0] out_motor_lf_r, out_motor_lb_r, out_motor_rb_r, out_motor_rf_r;
  logic               out_saturated_r;
  res_t               wz_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wheel_radius_r <= RADIUS_RESET;
      half_length_r  <= HALF_LENGTH_RESET;
      gear_ratio_r   <= GEAR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WHEEL_RADIUS: wheel_radius_r <= cfg_wdata;
        CFG_HALF_LENGTH:  half_length_r  <= cfg_wdata;
        CFG_GEAR_RATIO:   gear_ratio_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign en9 = !out_valid_r || out_ready;
  assign en8 = !v8_r || divb_in_ready;
  assign en7 = !v7_r || en8;
  assign en6 = !v6_r || en7;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || diva_in_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      v8_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= diva_out_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
      if (en9) out_valid_r <= divb_out_valid;
    end
  end

  // Stage 1: rpm scaling products, the vx/vy sum and difference, and the yaw term of the inverse numerators.
  assign wheel_in[0] = in_wheel_lf;
  assign wheel_in[1] = in_wheel_lb;
  assign wheel_in[2] = in_wheel_rb;
  assign wheel_in[3] = in_wheel_rf;

  always_comb begin
    for (int i = 0; i < WHEELS; i++) begin
      s1_pf_nxt[i] = wheel_in[i] * $signed({1'b0, RPM2RAD});
    end
    s1_a_nxt = in_cmd_wz * $signed({1'b0, half_length_r});
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op_r  <= in_op;
      s1_pf_r  <= s1_pf_nxt;
      s1_a_r   <= s1_a_nxt;
      s1_dif_r <= {in_cmd_vx[31], in_cmd_vx} - {in_cmd_vy[31], in_cmd_vy};
      s1_sum_r <= {in_cmd_vx[31], in_cmd_vx} + {in_cmd_vy[31], in_cmd_vy};
    end
  end

  // Stage 2: signed dividends for the four wheel divisions.
  always_comb begin
    logic signed [NUM_W-1:0] dif_w;
    logic signed [NUM_W-1:0] sum_w;
    logic signed [NUM_W-1:0] a_w;
    dif_w = {{(NUM_W - 49){s1_dif_r[32]}}, s1_dif_r, 16'b0};
    sum_w = {{(NUM_W - 49){s1_sum_r[32]}}, s1_sum_r, 16'b0};
    a_w   = {{(NUM_W - 57){s1_a_r[56]}}, s1_a_r};
    if (s1_op_r == OP_INVERSE) begin
      s2_num_nxt[0] = dif_w - a_w;
      s2_num_nxt[1] = sum_w - a_w;
      s2_num_nxt[2] = dif_w + a_w;
      s2_num_nxt[3] = sum_w + a_w;
    end else begin
      for (int i = 0; i < WHEELS; i++) begin
        s2_num_nxt[i] = {{(NUM_W - 46){s1_pf_r[i][45]}}, s1_pf_r[i]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_op_r  <= s1_op_r;
      s2_num_r <= s2_num_nxt;
    end
  end

  // Stage 3: divider setup with rounding offset and overflow detection.
  always_comb begin
    prep_t p;
    s3_d_nxt = (s2_op_r == OP_INVERSE) ? {2'b00, wheel_radius_r} : {2'b00, gear_ratio_r};
    s3_tag_nxt.op = s2_op_r;
    for (int i = 0; i < WHEELS; i++) begin
      p = div_prep(s2_num_r[i], s3_d_nxt);
      s3_rem_nxt[i]      = p.rem;
      s3_lo_nxt[i]       = p.lo;
      s3_tag_nxt.neg[i]  = p.neg;
      s3_tag_nxt.zero[i] = p.zero;
      s3_tag_nxt.ovf[i]  = p.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_rem_r <= s3_rem_nxt;
      s3_lo_r  <= s3_lo_nxt;
      s3_d_r   <= s3_d_nxt;
      s3_tag_r <= s3_tag_nxt;
    end
  end

  okin_div #(
    .LANES (WHEELS),
    .TW    ($bits(diva_tag_t))
  ) u_div_wheel (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v3_r),
    .in_ready  (diva_in_ready),
    .in_div    (s3_d_r),
    .in_rem    (s3_rem_r),
    .in_lo     (s3_lo_r),
    .in_tag    (s3_tag_r),
    .out_valid (diva_out_valid),
    .out_ready (en4),
    .out_q     (qa),
    .out_tag   (qa_tag)
  );

  // Stage 4: wheel rad/s with clipping.
  always_comb begin
    res_t r;
    s4_sat_nxt = 1'b0;
    for (int i = 0; i < WHEELS; i++) begin
      r = div_result(qa[i], qa_tag.neg[i], qa_tag.zero[i], qa_tag.ovf[i]);
      s4_r_nxt[i] = r.val;
      s4_sat_nxt  = s4_sat_nxt | r.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      s4_op_r  <= qa_tag.op;
      s4_sat_r <= s4_sat_nxt;
      s4_r_r   <= s4_r_nxt;
    end
  end

  // Stage 5: body sums, or wheel speed times gear ratio.
  always_comb begin
    logic signed [33:0] e [WHEELS];
    for (int i = 0; i < WHEELS; i++) begin
      e[i]          = {{2{s4_r_r[i][31]}}, s4_r_r[i]};
      s5_wg_nxt[i]  = s4_r_r[i] * $signed({1'b0, gear_ratio_r});
    end
    s5_sum_nxt[0] =  e[0] + e[1] + e[2] + e[3];
    s5_sum_nxt[1] = -e[0] + e[1] - e[2] + e[3];
    s5_sum_nxt[2] = -e[0] - e[1] + e[2] + e[3];
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      s5_op_r  <= s4_op_r;
      s5_sat_r <= s4_sat_r;
      s5_sum_r <= s5_sum_nxt;
      s5_wg_r  <= s5_wg_nxt;
    end
  end

  // Stage 6: sums times radius, or rounding of the geared speed.
  always_comb begin
    logic signed [56:0] x;
    for (int k = 0; k < 3; k++) begin
      s6_pr_nxt[k] = s5_sum_r[k] * $signed({1'b0, wheel_radius_r});
    end
    for (int i = 0; i < WHEELS; i++) begin
      x = s5_wg_r[i] + 57'sd32768 - {56'd0, s5_wg_r[i][56]};
      s6_t_nxt[i] = x[56:16];
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      s6_op_r  <= s5_op_r;
      s6_sat_r <= s5_sat_r;
      s6_pr_r  <= s6_pr_nxt;
      s6_t_r   <= s6_t_nxt;
    end
  end

  // Stage 7: body vx and vy, or the rpm conversion product.
  always_comb begin
    logic signed [58:0] x;
    res_t               r0;
    res_t               r1;
    x  = s6_pr_r[0] + 59'sd131072 - {58'd0, s6_pr_r[0][58]};
    r0 = sat32({{23{x[58]}}, x[58:18]});
    x  = s6_pr_r[1] + 59'sd131072 - {58'd0, s6_pr_r[1][58]};
    r1 = sat32({{23{x[58]}}, x[58:18]});
    if (s6_op_r == OP_FORWARD) begin
      s7_vx_nxt  = r0.val;
      s7_vy_nxt  = r1.val;
      s7_sat_nxt = s6_sat_r | r0.sat | r1.sat;
    end else begin
      s7_vx_nxt  = '0;
      s7_vy_nxt  = '0;
      s7_sat_nxt = s6_sat_r;
    end
    for (int i = 0; i < WHEELS; i++) begin
      s7_m_nxt[i] = s6_t_r[i] * $signed({1'b0, RAD2RPM});
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      s7_op_r   <= s6_op_r;
      s7_sat_r  <= s7_sat_nxt;
      s7_vx_r   <= s7_vx_nxt;
      s7_vy_r   <= s7_vy_nxt;
      s7_wnum_r <= s6_pr_r[2];
      s7_m_r    <= s7_m_nxt;
    end
  end

  // Stage 8: yaw divider setup, or final motor rounding and clipping.
  always_comb begin
    prep_t              p;
    res_t               r;
    logic signed [61:0] x;
    logic               msat;
    msat = 1'b0;
    p = div_prep(s7_wnum_r, {half_length_r, 2'b00});
    s8_rem_nxt[0]   = p.rem;
    s8_lo_nxt[0]    = p.lo;
    s8_tag_nxt.op   = s7_op_r;
    s8_tag_nxt.neg  = p.neg;
    s8_tag_nxt.zero = p.zero;
    s8_tag_nxt.ovf  = p.ovf;
    s8_tag_nxt.vx   = s7_vx_r;
    s8_tag_nxt.vy   = s7_vy_r;
    for (int i = 0; i < WHEELS; i++) begin
      x = s7_m_r[i] + 62'sd32768 - {61'd0, s7_m_r[i][61]};
      r = sat32({{18{x[61]}}, x[61:16]});
      if (s7_op_r == OP_INVERSE) begin
        s8_tag_nxt.motor[i] = r.val;
        msat = msat | r.sat;
      end else begin
        s8_tag_nxt.motor[i] = '0;
      end
    end
    s8_tag_nxt.sat = s7_sat_r | msat;
  end

  always_ff @(posedge clk) begin
    if (en8) begin
      s8_rem_r <= s8_rem_nxt;
      s8_lo_r  <= s8_lo_nxt;
      s8_tag_r <= s8_tag_nxt;
    end
  end

  okin_div #(
    .LANES (1),
    .TW    ($bits(divb_tag_t))
  ) u_div_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (v8_r),
    .in_ready  (divb_in_ready),
    .in_div    ({half_length_r, 2'b00}),
    .in_rem    (s8_rem_r),
    .in_lo     (s8_lo_r),
    .in_tag    (s8_tag_r),
    .out_valid (divb_out_valid),
    .out_ready (en9),
    .out_q     (qb),
    .out_tag   (qb_tag)
  );

  assign wz_res = div_result(qb[0], qb_tag.neg, qb_tag.zero, qb_tag.ovf);

  always_ff @(posedge clk) begin
    if (en9) begin
      out_body_vx_r  <= qb_tag.vx;
      out_body_vy_r  <= qb_tag.vy;
      out_motor_lf_r <= qb_tag.motor[0];
      out_motor_lb_r <= qb_tag.motor[1];
      out_motor_rb_r <= qb_tag.motor[2];
      out_motor_rf_r <= qb_tag.motor[3];
      if (qb_tag.op == OP_FORWARD) begin
        out_body_wz_r   <= wz_res.val;
        out_saturated_r <= qb_tag.sat | wz_res.sat;
      end else begin
        out_body_wz_r   <= '0;
        out_saturated_r <= qb_tag.sat;
      end
    end
  end

  assign in_ready      = en1;
  assign out_valid     = out_valid_r;
  assign out_body_vx   = out_body_vx_r;
  assign out_body_vy   = out_body_vy_r;
  assign out_body_wz   = out_body_wz_r;
  assign out_motor_lf  = out_motor_lf_r;
  assign out_motor_lb  = out_motor_lb_r;
  assign out_motor_rb  = out_motor_rb_r;
  assign out_motor_rf  = out_motor_rf_r;
  assign out_saturated = out_saturated_r;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v1_r)
    else $error("accepted transfer did not enter the first stage");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_motor_lf_r != '0 || out_motor_lb_r != '0 ||
                    out_motor_rb_r != '0 || out_motor_rf_r != '0)
    |-> (out_body_vx_r == '0 && out_body_vy_r == '0 && out_body_wz_r == '0))
    else $error("body and motor results both nonzero");

  a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && cfg_index == CFG_GEAR_RATIO |=> gear_ratio_r == $past(cfg_wdata))
    else $error("gear ratio register write lost");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import okin_pkg::*;

  localparam int DRAIN_CYCLES = 90;

  typedef struct packed {
    logic [6:0][31:0] val;
    logic             sat;
  } kin_result_t;

  class kin_scoreboard;
    kin_result_t pending_q[$];
    longint unsigned radius, half_len, gear;
    int errors;
    int checked;
    int forward_cnt, inverse_cnt, sat_cnt;

    function new();
      radius = RADIUS_RESET;
      half_len = HALF_LENGTH_RESET;
      gear = GEAR_RESET;
      errors = 0;
      checked = 0;
      forward_cnt = 0;
      inverse_cnt = 0;
      sat_cnt = 0;
    endfunction

    function longint round_div(longint num, longint unsigned den);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function longint clip32(longint v, inout bit s);
      if (v > 64'sd2147483647) begin
        s = 1'b1;
        return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
        s = 1'b1;
        return -64'sd2147483648;
      end
      return v;
    endfunction

    function longint safe_div(longint num, longint unsigned den, inout bit s);
      if (den == 0) begin
        if (num == 0) return 0;
        s = 1'b1;
        return (num > 0) ? 64'sd2147483647 : -64'sd2147483648;
      end
      return clip32(round_div(num, den), s);
    endfunction

    function void note_input(logic op, logic signed [3:0][31:0] wheel,
                             logic signed [31:0] vx_in, logic signed [31:0] vy_in,
                             logic signed [31:0] wz_in);
      longint res[7];
      longint r[4];
      longint n[4];
      longint sx, sy, sw, vx, vy, wz, a, w, t;
      bit s;
      kin_result_t e;
      s = 1'b0;
      for (int i = 0; i < 7; i++) res[i] = 0;
      if (op == OP_FORWARD) begin
        forward_cnt++;
        for (int i = 0; i < 4; i++)
          r[i] = safe_div(longint'($signed(wheel[i])) * 6862, gear, s);
        sx = r[0] + r[1] + r[2] + r[3];
        sy = -r[0] + r[1] - r[2] + r[3];
        sw = -r[0] - r[1] + r[2] + r[3];
        res[0] = safe_div(sx * longint'(radius), 64'd262144, s);
        res[1] = safe_div(sy * longint'(radius), 64'd262144, s);
        res[2] = safe_div(sw * longint'(radius), 4 * half_len, s);
      end else begin
        inverse_cnt++;
        vx = vx_in;
        vy = vy_in;
        wz = wz_in;
        a = wz * longint'(half_len);
        n[0] = (vx - vy) * 65536 - a;
        n[1] = (vx + vy) * 65536 - a;
        n[2] = (vx - vy) * 65536 + a;
        n[3] = (vx + vy) * 65536 + a;
        for (int i = 0; i < 4; i++) begin
          w = safe_div(n[i], radius, s);
          t = round_div(w * longint'(gear), 65536);
          res[3 + i] = clip32(round_div(t * 625823, 65536), s);
        end
      end
      for (int i = 0; i < 7; i++) e.val[i] = res[i][31:0];
      e.sat = s;
      if (s) sat_cnt++;
      pending_q.push_back(e);
    endfunction

    function void check_result(kin_result_t act);
      kin_result_t e;
      string names[7];
      names = '{"body_vx", "body_vy", "body_wz", "motor_lf", "motor_lb",
                "motor_rb", "motor_rf"};
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result transfer with nothing expected", $time);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      for (int i = 0; i < 7; i++)
        if (e.val[i] !== act.val[i]) begin
          errors++;
          $display("%0t: %s expected %0d actual %0d", $time, names[i],
                   $signed(e.val[i]), $signed(act.val[i]));
        end
      if (e.sat !== act.sat) begin
        errors++;
        $display("%0t: saturated expected %0b actual %0b", $time, e.sat, act.sat);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = CFG_WHEEL_RADIUS;
  logic [23:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = OP_FORWARD;
  logic signed [31:0] in_wheel_lf = '0, in_wheel_lb = '0, in_wheel_rb = '0;
  logic signed [31:0] in_wheel_rf = '0;
  logic signed [31:0] in_cmd_vx = '0, in_cmd_vy = '0, in_cmd_wz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_body_vx, out_body_vy, out_body_wz;
  logic signed [31:0] out_motor_lf, out_motor_lb, out_motor_rb, out_motor_rf;
  logic out_saturated;

  kin_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int transfers_in = 0;

  always #1 clk = ~clk;

  omni4_wheel_kinematics DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_wheel_lf(in_wheel_lf), .in_wheel_lb(in_wheel_lb),
    .in_wheel_rb(in_wheel_rb), .in_wheel_rf(in_wheel_rf),
    .in_cmd_vx(in_cmd_vx), .in_cmd_vy(in_cmd_vy), .in_cmd_wz(in_cmd_wz),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_body_vx(out_body_vx), .out_body_vy(out_body_vy),
    .out_body_wz(out_body_wz), .out_motor_lf(out_motor_lf),
    .out_motor_lb(out_motor_lb), .out_motor_rb(out_motor_rb),
    .out_motor_rf(out_motor_rf), .out_saturated(out_saturated)
  );

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    kin_result_t act;
    if (rst_n && in_valid && in_ready) begin
      sb.note_input(in_op, {in_wheel_rf, in_wheel_rb, in_wheel_lb, in_wheel_lf},
                    in_cmd_vx, in_cmd_vy, in_cmd_wz);
      transfers_in++;
    end
    if (rst_n && out_valid && out_ready) begin
      act.val = {out_motor_rf, out_motor_rb, out_motor_lb, out_motor_lf,
                 out_body_wz, out_body_vy, out_body_vx};
      act.sat = out_saturated;
      sb.check_result(act);
    end
  end

  function automatic logic [31:0] rand_field();
    logic [31:0] picks[6];
    picks = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h0001_0000};
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 6000)) - 3000) <<< 16 | $urandom_range(0, 65535);
      2: return picks[$urandom_range(5)];
      default: return 32'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_item(logic op, logic [31:0] lf, logic [31:0] lb, logic [31:0] rb,
                           logic [31:0] rf, logic [31:0] vx, logic [31:0] vy,
                           logic [31:0] wz);
    int seen;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_wheel_lf <= lf;
    in_wheel_lb <= lb;
    in_wheel_rb <= rb;
    in_wheel_rf <= rf;
    in_cmd_vx <= vx;
    in_cmd_vy <= vy;
    in_cmd_wz <= wz;
    seen = transfers_in;
    do @(negedge clk); while (transfers_in == seen);
  endtask

  task automatic send_random();
    send_item(1'($urandom_range(1)), rand_field(), rand_field(), rand_field(), rand_field(),
              rand_field(), rand_field(), rand_field());
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_WHEEL_RADIUS: sb.radius = data;
      CFG_HALF_LENGTH: sb.half_len = data;
      default: sb.gear = data;
    endcase
  endtask

  task automatic set_geometry(logic [23:0] r, logic [23:0] l, logic [23:0] g);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    write_cfg(CFG_WHEEL_RADIUS, r);
    write_cfg(CFG_HALF_LENGTH, l);
    write_cfg(CFG_GEAR_RATIO, g);
  endtask

  initial begin
    logic [23:0] geo[10][3];
    geo = '{'{24'd6554, 24'd19661, 24'd65536}, '{24'd66, 24'd66, 24'd1},
            '{24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF}, '{24'd0, 24'd19661, 24'd65536},
            '{24'd6554, 24'd0, 24'd65536}, '{24'd6554, 24'd19661, 24'd0},
            '{24'd3277, 24'd13107, 24'd1966080}, '{24'd66, 24'hFF_FFFF, 24'd65536},
            '{24'hFF_FFFF, 24'd66, 24'd1}, '{24'd0, 24'd0, 24'd0}};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_FORWARD, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_FORWARD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              '0, '0, '0);
    send_item(OP_FORWARD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              '0, '0, '0);
    send_item(OP_FORWARD, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    send_item(OP_FORWARD, 32'h0064_0000, 32'hFF9C_0000, 32'h0064_0000, 32'h0032_0000,
              '0, '0, '0);
    send_item(OP_FORWARD, 32'h1, 32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, '0, '0, '0);
    send_item(OP_INVERSE, '0, '0, '0, '0, '0, '0, '0);
    send_item(OP_INVERSE, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_item(OP_INVERSE, '0, '0, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_INVERSE, '0, '0, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    send_item(OP_INVERSE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
              32'h0001_0000, 32'h0000_8000, 32'hFFFF_0000);
    send_item(OP_INVERSE, '0, '0, '0, '0, 32'h1, 32'hFFFF_FFFF, 32'h1);
    send_item(OP_INVERSE, '0, '0, '0, '0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);

    for (int p = 0; p < 10; p++) begin
      set_geometry(geo[p][0], geo[p][1], geo[p][2]);
      for (int m = 0; m < 4; m++) begin
        send_idle_pct = (m == 1) ? 85 : (m == 3) ? 27 : 0;
        recv_stall_pct = (m == 2) ? 85 : (m == 3) ? 27 : 0;
        for (int k = 0; k < 28; k++) begin
          if (p == 0 && m == 0 && k == 14) wait_drained();
          send_random();
        end
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.pending_q.size() != 0) sb.errors++;
    $display("Checked %0d results: %0d forward, %0d inverse, %0d saturated.",
             sb.checked, sb.forward_cnt, sb.inverse_cnt, sb.sat_cnt);
    $display("Ten register settings, including zero and full-scale values, under four flow patterns.");
    if (sb.errors == 0) begin
      $display("omni4_wheel_kinematics test passed");
    end else begin
      $display("omni4_wheel_kinematics test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("omni4_wheel_kinematics test failed");
    $finish;
  end

endmodule
